/* hdl/assert_macros.svh */
// assertion helpers for the rtl, used by yuvc_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define YUVC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define YUVC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define YUVC_ASSERT(lbl, clk, rst_n, prop, msg)
`define YUVC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* hdl/yuvc_pkg.sv */
`default_nettype none

package yuvc_pkg;

    localparam int STORE_BYTES   = 8192;
    localparam int MAX_DIMENSION = 256;
    localparam int STORE_AW      = $clog2(STORE_BYTES);

    // field widths
    localparam int DIM_W    = 9;
    localparam int STRIDE_W = 13;
    localparam int CPS_W    = 3;
    localparam int COORD_W  = 8;
    localparam int BYTE_W   = 8;
    localparam int SADDR_W  = 13;

    // input tdata layout
    localparam int ADDR_LSB = 0;
    localparam int DATA_LSB = ADDR_LSB + SADDR_W;
    localparam int X_LSB    = DATA_LSB + BYTE_W;
    localparam int Y_LSB    = X_LSB + COORD_W;
    localparam int S_TDATA_W = ((Y_LSB + COORD_W + 7) / 8) * 8;
    localparam int M_TDATA_W = 4 * BYTE_W;

    // address arithmetic widths
    localparam int PY_W   = STRIDE_W + COORD_W;
    localparam int PC_W   = STRIDE_W + COORD_W - 1;
    localparam int PX_W   = COORD_W - 1 + CPS_W;
    localparam int AREA_W = 2 * DIM_W;
    localparam int ADDR_W = PY_W + 1;

    // colour arithmetic
    localparam int SUM_W     = 21;
    localparam int CH_BITS   = 18;
    localparam int CH_SHIFT  = 10;
    localparam int COEF_Y    = 1192;
    localparam int COEF_RV   = 1634;
    localparam int COEF_GV   = 833;
    localparam int COEF_GU   = 400;
    localparam int COEF_BU   = 2066;
    localparam int Y_OFFSET  = 16;
    localparam int C_OFFSET  = 128;
    localparam int ALPHA_OPAQUE = 255;

    // register port
    localparam int NUM_REGS = 6;
    localparam int PADDR_W  = $clog2(NUM_REGS * 4);
    localparam int PDATA_W  = 32;

    typedef enum logic [2:0] {
        REG_FORMAT = 3'd0,
        REG_WIDTH  = 3'd1,
        REG_HEIGHT = 3'd2,
        REG_LSTRIDE = 3'd3,
        REG_CSTRIDE = 3'd4,
        REG_CPSTRIDE = 3'd5
    } reg_idx_t;

    typedef enum logic [1:0] {
        FMT_I420 = 2'd0,
        FMT_YV12 = 2'd1,
        FMT_NV12 = 2'd2,
        FMT_NV21 = 2'd3
    } pix_fmt_t;

    typedef enum logic {
        OP_WRITE   = 1'b0,
        OP_CONVERT = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        RD_Y = 2'd0,
        RD_U = 2'd1,
        RD_V = 2'd2
    } rd_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL1,
        ST_ADDR,
        ST_RDY,
        ST_RDU,
        ST_RDV,
        ST_PROD,
        ST_OUT
    } state_t;

    typedef struct packed {
        pix_fmt_t              pixel_format;
        logic [DIM_W-1:0]      frame_width;
        logic [DIM_W-1:0]      frame_height;
        logic [STRIDE_W-1:0]   luma_row_stride;
        logic [STRIDE_W-1:0]   chroma_row_stride;
        logic [CPS_W-1:0]      chroma_pixel_stride;
    } cfg_t;

    typedef struct packed {
        logic    capture;
        logic    wr_en;
        logic    calc_prod;
        logic    calc_addr;
        logic    chk;
        rd_sel_t rd_sel;
        logic    lat_y;
        logic    lat_u;
        logic    calc_mult;
        logic    load_out;
    } cmd_t;

    typedef struct packed {
        logic bad;
        logic out_free;
    } stat_t;

endpackage

`default_nettype wire

/* hdl/yuvc_regs.sv */
`default_nettype none

module yuvc_regs
    import yuvc_pkg::*;
(
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               psel,
    input  wire logic               penable,
    input  wire logic               pwrite,
    input  wire logic [PADDR_W-1:0] paddr,
    input  wire logic [PDATA_W-1:0] pwdata,
    output logic      [PDATA_W-1:0] prdata,
    output logic                    pready,
    output cfg_t                    cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    logic     wr;

    assign pready = 1'b1;
    assign idx    = reg_idx_t'(paddr[PADDR_W-1:2]);
    assign wr     = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr) begin
            unique case (idx)
                REG_FORMAT:   cfg_next.pixel_format = pix_fmt_t'(pwdata[1:0]);
                REG_WIDTH:    cfg_next.frame_width = pwdata[DIM_W-1:0];
                REG_HEIGHT:   cfg_next.frame_height = pwdata[DIM_W-1:0];
                REG_LSTRIDE:  cfg_next.luma_row_stride = pwdata[STRIDE_W-1:0];
                REG_CSTRIDE:  cfg_next.chroma_row_stride = pwdata[STRIDE_W-1:0];
                REG_CPSTRIDE: cfg_next.chroma_pixel_stride = pwdata[CPS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_FORMAT:   prdata = PDATA_W'(cfg_reg.pixel_format);
            REG_WIDTH:    prdata = PDATA_W'(cfg_reg.frame_width);
            REG_HEIGHT:   prdata = PDATA_W'(cfg_reg.frame_height);
            REG_LSTRIDE:  prdata = PDATA_W'(cfg_reg.luma_row_stride);
            REG_CSTRIDE:  prdata = PDATA_W'(cfg_reg.chroma_row_stride);
            REG_CPSTRIDE: prdata = PDATA_W'(cfg_reg.chroma_pixel_stride);
            default:      prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.pixel_format        <= FMT_I420;
            cfg_reg.frame_width         <= DIM_W'(64);
            cfg_reg.frame_height        <= DIM_W'(64);
            cfg_reg.luma_row_stride     <= STRIDE_W'(64);
            cfg_reg.chroma_row_stride   <= STRIDE_W'(32);
            cfg_reg.chroma_pixel_stride <= CPS_W'(1);
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

/* hdl/yuvc_dp.sv */
`default_nettype none

module yuvc_dp
    import yuvc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cfg_t                 cfg,
    input  wire cmd_t                 cmd,
    input  wire logic [S_TDATA_W-1:0] s_tdata,
    input  wire logic                 m_tready,
    output logic                      m_tvalid,
    output logic      [M_TDATA_W-1:0] m_tdata,
    output logic                      m_tuser,
    output stat_t                     status
);

    function automatic logic [BYTE_W-1:0] clamp_ch(input logic signed [SUM_W-1:0] v);
        logic [BYTE_W-1:0] res;
        if (v < 0) begin
            res = '0;
        end else if (v[SUM_W-1:CH_BITS] != '0) begin
            res = '1;
        end else begin
            res = v[CH_BITS-1:CH_SHIFT];
        end
        return res;
    endfunction

    logic [BYTE_W-1:0] frame_mem [STORE_BYTES];

    logic [SADDR_W-1:0] s_addr;
    logic [BYTE_W-1:0]  s_data;
    logic               wr_ok;

    logic [COORD_W-1:0] x_reg, y_reg;
    logic [PY_W-1:0]    py_reg, py_next;
    logic [PC_W-1:0]    pc_reg, pc_next;
    logic [PX_W-1:0]    px_reg, px_next;
    logic [AREA_W-1:0]  area_reg, area_next;
    logic               pix_bad_reg, pix_bad_next;
    logic [ADDR_W-1:0]  yi_reg, ui_reg, vi_reg;
    logic [ADDR_W-1:0]  yi_next, ui_next, vi_next;
    logic               oor_reg;
    logic [BYTE_W-1:0]  rd_q_reg, yb_reg, ub_reg;

    logic                    planar;
    logic [STRIDE_W-1:0]     mul_a, mul_c;
    logic [ADDR_W-1:0]       off, first, second, pair;
    logic [AREA_W-3:0]       quarter;
    logic [ADDR_W-1:0]       rd_addr;
    logic                    bad;

    logic [BYTE_W-1:0]       cy;
    logic signed [SUM_W-1:0] cy_s, cu, cv;
    logic signed [SUM_W-1:0] p_y_reg, p_rv_reg, p_gv_reg, p_gu_reg, p_bu_reg;
    logic signed [SUM_W-1:0] r_sum, g_sum, b_sum;

    logic                 out_valid_reg;
    logic [BYTE_W-1:0]    r_reg, g_reg, b_reg, a_reg;
    logic                 oor_out_reg;

    assign s_addr = s_tdata[ADDR_LSB +: SADDR_W];
    assign s_data = s_tdata[DATA_LSB +: BYTE_W];
    assign wr_ok  = cmd.wr_en && (32'(s_addr) < STORE_BYTES);

    assign planar = (cfg.pixel_format == FMT_I420) || (cfg.pixel_format == FMT_YV12);

    // row products, frame area and the pixel range check
    always_comb begin
        mul_a = planar ? cfg.luma_row_stride : STRIDE_W'(cfg.frame_width);
        mul_c = planar ? cfg.chroma_row_stride : STRIDE_W'(cfg.frame_width);
        py_next   = PY_W'(mul_a) * PY_W'(y_reg);
        pc_next   = PC_W'(mul_c) * PC_W'(y_reg[COORD_W-1:1]);
        px_next   = PX_W'(x_reg[COORD_W-1:1]) * PX_W'(cfg.chroma_pixel_stride);
        area_next = AREA_W'(cfg.frame_width) * AREA_W'(cfg.frame_height);
        pix_bad_next = (cfg.frame_width == '0) || (cfg.frame_height == '0) ||
                       (32'(cfg.frame_width) > MAX_DIMENSION) ||
                       (32'(cfg.frame_height) > MAX_DIMENSION) ||
                       ({1'b0, x_reg} >= cfg.frame_width) ||
                       ({1'b0, y_reg} >= cfg.frame_height);
    end

    // byte offsets of the three samples
    always_comb begin
        quarter = area_reg[AREA_W-1:2];
        first   = ADDR_W'(area_reg);
        second  = ADDR_W'({quarter, 2'b00}) + ADDR_W'(quarter);
        off     = ADDR_W'(pc_reg) + ADDR_W'(px_reg);
        pair    = ADDR_W'(area_reg) + ADDR_W'(pc_reg) + ADDR_W'({x_reg[COORD_W-1:1], 1'b0});
        yi_next = ADDR_W'(py_reg) + ADDR_W'(x_reg);
        case (cfg.pixel_format)
            FMT_YV12: begin
                ui_next = second + off;
                vi_next = first + off;
            end
            FMT_NV12: begin
                ui_next = pair;
                vi_next = pair + ADDR_W'(1);
            end
            FMT_NV21: begin
                ui_next = pair + ADDR_W'(1);
                vi_next = pair;
            end
            default: begin
                ui_next = first + off;
                vi_next = second + off;
            end
        endcase
    end

    assign bad = pix_bad_reg ||
                 (yi_reg >= ADDR_W'(STORE_BYTES)) ||
                 (ui_reg >= ADDR_W'(STORE_BYTES)) ||
                 (vi_reg >= ADDR_W'(STORE_BYTES));

    always_comb begin
        case (cmd.rd_sel)
            RD_U:    rd_addr = ui_reg;
            RD_V:    rd_addr = vi_reg;
            default: rd_addr = yi_reg;
        endcase
    end

    // single-port frame store
    always_ff @(posedge aclk) begin
        if (wr_ok) begin
            frame_mem[STORE_AW'(s_addr)] <= s_data;
        end else begin
            rd_q_reg <= frame_mem[STORE_AW'(rd_addr)];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            x_reg <= s_tdata[X_LSB +: COORD_W];
            y_reg <= s_tdata[Y_LSB +: COORD_W];
        end
        if (cmd.calc_prod) begin
            py_reg      <= py_next;
            pc_reg      <= pc_next;
            px_reg      <= px_next;
            area_reg    <= area_next;
            pix_bad_reg <= pix_bad_next;
        end
        if (cmd.calc_addr) begin
            yi_reg <= yi_next;
            ui_reg <= ui_next;
            vi_reg <= vi_next;
        end
        if (cmd.chk) begin
            oor_reg <= bad;
        end
        if (cmd.lat_y) begin
            yb_reg <= rd_q_reg;
        end
        if (cmd.lat_u) begin
            ub_reg <= rd_q_reg;
        end
    end

    // centred samples, v comes straight from the store
    always_comb begin
        cy   = (yb_reg >= BYTE_W'(Y_OFFSET)) ? yb_reg - BYTE_W'(Y_OFFSET) : '0;
        cy_s = SUM_W'($signed({1'b0, cy}));
        cu   = SUM_W'($signed({1'b0, ub_reg})) - SUM_W'(C_OFFSET);
        cv   = SUM_W'($signed({1'b0, rd_q_reg})) - SUM_W'(C_OFFSET);
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc_mult) begin
            p_y_reg  <= cy_s * SUM_W'(COEF_Y);
            p_rv_reg <= cv * SUM_W'(COEF_RV);
            p_gv_reg <= cv * SUM_W'(COEF_GV);
            p_gu_reg <= cu * SUM_W'(COEF_GU);
            p_bu_reg <= cu * SUM_W'(COEF_BU);
        end
    end

    assign r_sum = p_y_reg + p_rv_reg;
    assign g_sum = p_y_reg - p_gv_reg - p_gu_reg;
    assign b_sum = p_y_reg + p_bu_reg;

    // output register
    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            if (oor_reg) begin
                r_reg <= '0;
                g_reg <= '0;
                b_reg <= '0;
                a_reg <= '0;
                oor_out_reg <= 1'b1;
            end else begin
                r_reg <= clamp_ch(r_sum);
                g_reg <= clamp_ch(g_sum);
                b_reg <= clamp_ch(b_sum);
                a_reg <= BYTE_W'(ALPHA_OPAQUE);
                oor_out_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {a_reg, b_reg, g_reg, r_reg};
    assign m_tuser  = oor_out_reg;

    assign status.bad      = bad;
    assign status.out_free = !out_valid_reg || m_tready;

endmodule

`default_nettype wire

/* hdl/yuvc_ctrl.sv */
`default_nettype none
`include "assert_macros.svh"

module yuvc_ctrl
    import yuvc_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    input  wire logic  s_tuser,
    input  wire stat_t status,
    output logic       s_tready,
    output cmd_t       cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_Y;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    if (s_tuser == OP_WRITE) begin
                        cmd.wr_en = 1'b1;
                    end else begin
                        cmd.capture = 1'b1;
                        state_next  = ST_MUL1;
                    end
                end
            end
            ST_MUL1: begin
                cmd.calc_prod = 1'b1;
                state_next    = ST_ADDR;
            end
            ST_ADDR: begin
                cmd.calc_addr = 1'b1;
                state_next    = ST_RDY;
            end
            ST_RDY: begin
                cmd.chk    = 1'b1;
                cmd.rd_sel = RD_Y;
                state_next = status.bad ? ST_OUT : ST_RDU;
            end
            ST_RDU: begin
                cmd.rd_sel = RD_U;
                cmd.lat_y  = 1'b1;
                state_next = ST_RDV;
            end
            ST_RDV: begin
                cmd.rd_sel = RD_V;
                cmd.lat_u  = 1'b1;
                state_next = ST_PROD;
            end
            ST_PROD: begin
                cmd.calc_mult = 1'b1;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (status.out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    `YUVC_ASSERT_ALWAYS(a_rst_idle, aclk, !aresetn |=> state_reg == ST_IDLE, "not idle after reset")
    `YUVC_ASSERT(a_conv_start, aclk, aresetn, (s_tvalid && s_tready && s_tuser == OP_CONVERT) |=> state_reg == ST_MUL1, "convert did not start")
    `YUVC_ASSERT(a_write_idle, aclk, aresetn, (s_tvalid && s_tready && s_tuser == OP_WRITE) |=> state_reg == ST_IDLE, "write left idle")
    `YUVC_ASSERT(a_load_free, aclk, aresetn, cmd.load_out |-> status.out_free, "output overwritten")

endmodule

`default_nettype wire

/* hdl/yuv420_frame_to_rgba_top.sv */
// channel   | dir | handshake          | payload
// s_        | in  | s_tvalid/s_tready  | s_tdata: address, byte, x, y; s_tuser: operation
// m_        | out | m_tvalid/m_tready  | m_tdata: r, g, b, a; m_tuser: out_of_range
// apb       | in  | psel/penable       | six config registers at 4*index
//
// a write item is taken in ST_IDLE, which it does not leave; a convert steps through
// ST_MUL1, ST_ADDR, ST_RDY, ST_RDU, ST_RDV and ST_PROD to ST_OUT (straight from ST_RDY
// when the pixel or an index is out of range) and holds the input until back in ST_IDLE
// the three sample reads go one after another through the single store port
// aresetn is synchronous active low; it clears control and config, not the store
// a result waits in the output register while the next item is accepted; a
// convert holds in its last state until that register is free
`default_nettype none

module yuv420_frame_to_rgba_top
    import yuvc_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [S_TDATA_W-1:0] s_tdata,   // store_address, store_data, pixel_x, pixel_y
    input  wire logic                 s_tuser,   // operation
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic      [M_TDATA_W-1:0] m_tdata,   // red, green, blue, alpha
    output logic                      m_tuser,   // out_of_range
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [PADDR_W-1:0]   paddr,
    input  wire logic [PDATA_W-1:0]   pwdata,
    output logic      [PDATA_W-1:0]   prdata,
    output logic                      pready
);

    cfg_t  cfg;
    cmd_t  cmd;
    stat_t status;

    yuvc_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    yuvc_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .status   (status),
        .s_tready (s_tready),
        .cmd      (cmd)
    );

    yuvc_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .cmd      (cmd),
        .s_tdata  (s_tdata),
        .m_tready (m_tready),
        .m_tvalid (m_tvalid),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .status   (status)
    );

endmodule

`default_nettype wire

/* tb/tb_yuv420_frame_to_rgba_top.sv */
module tb_yuv420_frame_to_rgba_top;
    timeunit 1ns;
    timeprecision 1ps;

    import yuvc_pkg::*;

    localparam int CLK_HALF       = 6;
    localparam int RESET_CYCLES   = 3;
    localparam int SETTLE_CYCLES  = 12;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int MAX_GAP        = 4;
    localparam int HOLD_OFF       = 80;
    localparam int PHASE_ITEMS    = 58;
    localparam int RANDOM_PHASES  = 8;

    // colour conversion, coefficients scaled by 1024
    localparam int CHANNEL_CEIL = 262143;
    localparam int FRAC_BITS    = 10;
    localparam int Y_GAIN       = 1192;
    localparam int R_FROM_V     = 1634;
    localparam int G_FROM_V     = 833;
    localparam int G_FROM_U     = 400;
    localparam int B_FROM_U     = 2066;
    localparam int LUMA_BLACK   = 16;
    localparam int CHROMA_ZERO  = 128;
    localparam logic [7:0] OPAQUE = 8'hff;

    // addresses past the last register, must be ignored
    localparam logic [PADDR_W-1:0] SPARE_REG_ADDR_A = PADDR_W'(NUM_REGS * 4);
    localparam logic [PADDR_W-1:0] SPARE_REG_ADDR_B = PADDR_W'((NUM_REGS + 1) * 4);

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic       out_of_range;
    } rgba_t;

    logic                 aclk     = 1'b0;
    logic                 aresetn  = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 m_tuser;
    logic                 psel     = 1'b0;
    logic                 penable  = 1'b0;
    logic                 pwrite   = 1'b0;
    logic [PADDR_W-1:0]   paddr    = '0;
    logic [PDATA_W-1:0]   pwdata   = '0;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    rgba_t pending_pixels[$];
    logic [7:0] frame_mirror [STORE_BYTES];
    bit         byte_written [STORE_BYTES];

    pix_fmt_t            cfg_format        = FMT_I420;
    logic [DIM_W-1:0]    cfg_width         = 64;
    logic [DIM_W-1:0]    cfg_height        = 64;
    logic [STRIDE_W-1:0] cfg_luma_stride   = 64;
    logic [STRIDE_W-1:0] cfg_chroma_stride = 32;
    logic [CPS_W-1:0]    cfg_chroma_step   = 1;

    int error_count   = 0;
    int items_sent    = 0;
    int results_seen  = 0;
    int quiet_cycles  = 0;
    int receiver_hold = 0;
    bit no_gaps       = 1'b0;
    bit steady_flow   = 1'b0;

    yuv420_frame_to_rgba_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    // byte offsets of the luma, u and v samples; 0 when the frame size or the pixel is out of range
    function automatic bit locate_samples(input int unsigned x, input int unsigned y,
                                          output int unsigned yi, output int unsigned ui,
                                          output int unsigned vi);
        int unsigned w, h, area, off, pair;
        w = cfg_width;
        h = cfg_height;
        yi = 0;
        ui = 0;
        vi = 0;
        if (w == 0 || h == 0 || w > MAX_DIMENSION || h > MAX_DIMENSION || x >= w || y >= h)
            return 1'b0;
        area = w * h;
        if (cfg_format == FMT_I420 || cfg_format == FMT_YV12) begin
            off = int'(cfg_chroma_stride) * (y >> 1) + (x >> 1) * int'(cfg_chroma_step);
            yi = int'(cfg_luma_stride) * y + x;
            if (cfg_format == FMT_I420) begin
                ui = area + off;
                vi = (area / 4) * 5 + off;
            end else begin
                ui = (area / 4) * 5 + off;
                vi = area + off;
            end
        end else begin
            pair = area + (y >> 1) * w + 2 * (x >> 1);
            yi = y * w + x;
            ui = (cfg_format == FMT_NV12) ? pair : pair + 1;
            vi = (cfg_format == FMT_NV12) ? pair + 1 : pair;
        end
        return 1'b1;
    endfunction

    function automatic logic [7:0] channel_level(input int level);
        if (level > CHANNEL_CEIL) level = CHANNEL_CEIL;
        if (level < 0) level = 0;
        return 8'(level >>> FRAC_BITS);
    endfunction

    function automatic rgba_t predict_pixel(input int unsigned x, input int unsigned y);
        rgba_t px;
        int unsigned yi, ui, vi;
        int luma, cb, cr;
        px = '0;
        px.out_of_range = 1'b1;
        if (!locate_samples(x, y, yi, ui, vi)) return px;
        if (yi >= STORE_BYTES || ui >= STORE_BYTES || vi >= STORE_BYTES) return px;
        luma = int'(frame_mirror[yi]) - LUMA_BLACK;
        if (luma < 0) luma = 0;
        cb = int'(frame_mirror[ui]) - CHROMA_ZERO;
        cr = int'(frame_mirror[vi]) - CHROMA_ZERO;
        px.red   = channel_level(Y_GAIN * luma + R_FROM_V * cr);
        px.green = channel_level(Y_GAIN * luma - G_FROM_V * cr - G_FROM_U * cb);
        px.blue  = channel_level(Y_GAIN * luma + B_FROM_U * cb);
        px.alpha = OPAQUE;
        px.out_of_range = 1'b0;
        return px;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string field, input logic [7:0] want,
                                 input logic [7:0] got, input int index);
        if (got !== want)
            report_mismatch($sformatf("%s of result %0d: expected %0d, got %0d",
                                      field, index, want, got));
    endtask

    task automatic send_item(input op_t op, input logic [SADDR_W-1:0] addr,
                             input logic [7:0] data, input logic [7:0] x,
                             input logic [7:0] y);
        logic [S_TDATA_W-1:0] word;
        int gap;
        word = '0;
        word[ADDR_LSB +: SADDR_W] = addr;
        word[DATA_LSB +: BYTE_W]  = data;
        word[X_LSB +: COORD_W]    = x;
        word[Y_LSB +: COORD_W]    = y;
        gap = (no_gaps || steady_flow) ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        s_tuser  <= op;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
        if (op == OP_WRITE) begin
            if (int'(addr) < STORE_BYTES) begin
                frame_mirror[addr] = data;
                byte_written[addr] = 1'b1;
            end
        end else begin
            pending_pixels.push_back(predict_pixel(x, y));
        end
    endtask

    task automatic write_byte(input int unsigned addr, input logic [7:0] data);
        send_item(OP_WRITE, SADDR_W'(addr), data, 8'($urandom), 8'($urandom));
    endtask

    // fills any sample byte not yet written, or every one when refresh is set, so a convert never reads stale store
    task automatic convert_pixel(input int unsigned x, input int unsigned y, input bit refresh);
        int unsigned site[3];
        if (locate_samples(x, y, site[0], site[1], site[2])) begin
            for (int i = 0; i < 3; i++) begin
                if (site[i] < STORE_BYTES && (refresh || !byte_written[site[i]]))
                    write_byte(site[i], 8'($urandom));
            end
        end
        send_item(OP_CONVERT, SADDR_W'($urandom), 8'($urandom), 8'(x), 8'(y));
    endtask

    task automatic paint_pixel(input int unsigned x, input int unsigned y,
                               input logic [7:0] luma, input logic [7:0] cb,
                               input logic [7:0] cr);
        int unsigned yi, ui, vi;
        void'(locate_samples(x, y, yi, ui, vi));
        write_byte(yi, luma);
        write_byte(ui, cb);
        write_byte(vi, cr);
        send_item(OP_CONVERT, SADDR_W'($urandom), 8'($urandom), 8'(x), 8'(y));
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
    endtask

    task automatic quiesce();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [PDATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        while (!pready) @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        apb_write(PADDR_W'(int'(idx) * 4), value);
        case (idx)
            REG_FORMAT:   cfg_format        = pix_fmt_t'(value[1:0]);
            REG_WIDTH:    cfg_width         = value[DIM_W-1:0];
            REG_HEIGHT:   cfg_height        = value[DIM_W-1:0];
            REG_LSTRIDE:  cfg_luma_stride   = value[STRIDE_W-1:0];
            REG_CSTRIDE:  cfg_chroma_stride = value[STRIDE_W-1:0];
            REG_CPSTRIDE: cfg_chroma_step   = value[CPS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_frame(input pix_fmt_t fmt, input int unsigned w, input int unsigned h,
                             input int unsigned luma_stride, input int unsigned chroma_stride,
                             input int unsigned chroma_step);
        quiesce();
        write_register(REG_FORMAT, fmt);
        write_register(REG_WIDTH, w);
        write_register(REG_HEIGHT, h);
        write_register(REG_LSTRIDE, luma_stride);
        write_register(REG_CSTRIDE, chroma_stride);
        write_register(REG_CPSTRIDE, chroma_step);
    endtask

    task automatic random_item();
        int unsigned w, h, pick;
        bit framed;
        w = cfg_width;
        h = cfg_height;
        framed = (w >= 1 && w <= MAX_DIMENSION && h >= 1 && h <= MAX_DIMENSION);
        pick = $urandom_range(0, 99);
        if (pick < 70 && framed)
            convert_pixel($urandom_range(0, w - 1), $urandom_range(0, h - 1),
                          $urandom_range(0, 3) == 0);
        else if (pick < 85)
            convert_pixel($urandom_range(0, 255), $urandom_range(0, 255), 1'b0);
        else
            write_byte($urandom_range(0, STORE_BYTES - 1), 8'($urandom));
    endtask

    // reset frame settings, colours that hit both clamps and black (16, 128, 128)
    task automatic test_colour_extremes();
        paint_pixel(0, 0, 8'd0, 8'd0, 8'd0);
        paint_pixel(63, 63, 8'd255, 8'd255, 8'd255);
        paint_pixel(5, 2, 8'd16, 8'd128, 8'd128);
        paint_pixel(30, 41, 8'd255, 8'd0, 8'd255);
        paint_pixel(62, 1, 8'd235, 8'd255, 8'd0);
    endtask

    task automatic test_frame_edges();
        convert_pixel(63, 0, 1'b0);
        convert_pixel(64, 0, 1'b0);
        convert_pixel(0, 64, 1'b0);
        convert_pixel(255, 255, 1'b0);
    endtask

    task automatic test_register_extremes();
        set_frame(FMT_I420, 1, 1, 0, 0, 0);
        convert_pixel(0, 0, 1'b1);
        convert_pixel(1, 0, 1'b0);
        convert_pixel(0, 1, 1'b0);
        // zero and oversized dimensions flag every pixel
        set_frame(FMT_NV21, 0, 64, 64, 32, 1);
        convert_pixel(0, 0, 1'b0);
        set_frame(FMT_NV12, 64, 0, 64, 32, 1);
        convert_pixel(0, 0, 1'b0);
        set_frame(FMT_YV12, 257, 16, 257, 129, 1);
        convert_pixel(0, 0, 1'b0);
        set_frame(FMT_I420, 511, 511, 8191, 8191, 7);
        convert_pixel(1, 1, 1'b0);
        // chroma planes lie past the end of the store
        set_frame(FMT_I420, 256, 256, 8191, 8191, 4);
        convert_pixel(0, 0, 1'b0);
        convert_pixel(255, 255, 1'b0);
        set_frame(FMT_YV12, 40, 30, 45, 160, 7);
        convert_pixel(39, 29, 1'b0);
        convert_pixel(17, 9, 1'b0);
        quiesce();
        apb_write(SPARE_REG_ADDR_A, $urandom);
        apb_write(SPARE_REG_ADDR_B, $urandom);
        convert_pixel(20, 10, 1'b1);
    endtask

    task automatic test_random_phases();
        int unsigned w, h, cps, luma_stride, chroma_stride, phase_end;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            w = ($urandom_range(0, 3) == 0) ? $urandom_range(73, 200) : $urandom_range(1, 72);
            h = $urandom_range(1, 72);
            cps = ($urandom_range(0, 5) == 0) ? $urandom_range(5, 7) : $urandom_range(0, 4);
            luma_stride = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                       : w + $urandom_range(0, 16);
            chroma_stride = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 8191)
                                                         : ((w + 1) / 2) * cps + $urandom_range(0, 8);
            set_frame(pix_fmt_t'(phase % 4), w, h, luma_stride, chroma_stride, cps);
            phase_end = items_sent + PHASE_ITEMS;
            while (items_sent < phase_end) random_item();
        end
    endtask

    // result side blocked while items keep coming, so the input stalls
    task automatic test_backpressure();
        set_frame(FMT_NV12, 32, 24, 32, 16, 1);
        receiver_hold = HOLD_OFF;
        no_gaps = 1'b1;
        for (int i = 0; i < 12; i++)
            convert_pixel($urandom_range(0, 31), $urandom_range(0, 23), 1'b1);
        no_gaps = 1'b0;
        drain_results();
    endtask

    task automatic test_steady_flow();
        set_frame(FMT_NV21, 48, 40, 48, 24, 2);
        steady_flow = 1'b1;
        for (int i = 0; i < 45; i++)
            random_item();
        steady_flow = 1'b0;
    endtask

    initial begin
        int stall;
        @(posedge aclk);
        forever begin
            if (receiver_hold > 0) begin
                m_tready <= 1'b0;
                repeat (receiver_hold) @(posedge aclk);
                receiver_hold = 0;
            end
            stall = steady_flow ? 0 : $urandom_range(0, MAX_GAP);
            if (stall != 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    always @(posedge aclk) begin : check_results
        rgba_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got.red          = m_tdata[0 +: BYTE_W];
            got.green        = m_tdata[BYTE_W +: BYTE_W];
            got.blue         = m_tdata[2 * BYTE_W +: BYTE_W];
            got.alpha        = m_tdata[3 * BYTE_W +: BYTE_W];
            got.out_of_range = m_tuser;
            if (pending_pixels.size() == 0) begin
                report_mismatch($sformatf("result %0d arrived with no convert pending",
                                          results_seen));
            end else begin
                want = pending_pixels.pop_front();
                compare_field("red", want.red, got.red, results_seen);
                compare_field("green", want.green, got.green, results_seen);
                compare_field("blue", want.blue, got.blue, results_seen);
                compare_field("alpha", want.alpha, got.alpha, results_seen);
                compare_field("out_of_range", 8'(want.out_of_range), 8'(got.out_of_range),
                              results_seen);
            end
            results_seen++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || psel)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("yuv420_frame_to_rgba_top test failed");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_colour_extremes();
        test_frame_edges();
        test_register_extremes();
        test_random_phases();
        test_backpressure();
        test_steady_flow();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("yuv420_frame_to_rgba_top test passed");
        else
            $display("yuv420_frame_to_rgba_top test failed");
        $finish;
    end

endmodule
